// File: hw/rtl/ttbe_pkg.sv
// ----------------------------------------------------------------------------
// ttbe_pkg
// Shared constants, controller states and the command and status bundles
// for the tap tempo estimator.
// ----------------------------------------------------------------------------
package ttbe_pkg;

  // Window and time base
  localparam int unsigned TAP_WINDOW = 64;
  localparam int unsigned TIME_BITS  = 48;

  // Port field widths
  localparam int unsigned TS_W    = 48;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned AVG_W   = 48;
  localparam int unsigned BPM_W   = 34;

  // Internal widths
  localparam int unsigned IDX_W    = $clog2(TAP_WINDOW);
  localparam int unsigned CNT_W    = $clog2(TAP_WINDOW + 1);
  localparam int unsigned GAP_W    = $clog2(TAP_WINDOW);
  localparam int unsigned SUM_W    = TIME_BITS + GAP_W;
  localparam int unsigned REM_W    = TIME_BITS + 1;
  localparam int unsigned DIVCNT_W = $clog2(SUM_W + 1);

  // 60,000,000 us per minute times 256 fraction steps
  localparam logic [BPM_W-1:0] BPM_NUMERATOR = BPM_W'(64'd15360000000);

  // Request codes
  localparam logic REQ_TAP   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_WALK,
    ST_DRAIN,
    ST_AVG_LOAD,
    ST_AVG_DIV,
    ST_BPM_LOAD,
    ST_BPM_DIV,
    ST_BPM_STORE,
    ST_RESULT
  } ttbe_state_e;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic tap_write;
    logic walk_init;
    logic walk_step;
    logic zero_result;
    logic avg_load;
    logic div_step;
    logic bpm_load;
    logic bpm_store;
    logic out_load;
  } ttbe_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic multi;
    logic walk_last;
    logic no_gaps;
    logic div_last;
  } ttbe_sts_t;

endpackage

// File: hw/rtl/ttbe_ram.sv
// ----------------------------------------------------------------------------
// ttbe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ttbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ttbe_ctrl.sv
// ----------------------------------------------------------------------------
// ttbe_ctrl
// Sequencer: takes a request, walks the tap ring, runs the two divisions
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module ttbe_ctrl import ttbe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      req_type_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ttbe_cmd_t cmd_o,
  input  ttbe_sts_t sts_i
);

  ttbe_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        in_xfer;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (req_type_i == REQ_CLEAR) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_RESULT;
          end else begin
            cmd_o.tap_write = 1'b1;
            state_d         = ST_START;
          end
        end
      end
      ST_START: begin
        if (sts_i.multi) begin
          cmd_o.walk_init = 1'b1;
          state_d         = ST_WALK;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_AVG_LOAD;
      end
      ST_AVG_LOAD: begin
        if (sts_i.no_gaps) begin
          cmd_o.zero_result = 1'b1;
          state_d           = ST_RESULT;
        end else begin
          cmd_o.avg_load = 1'b1;
          state_d        = ST_AVG_DIV;
        end
      end
      ST_AVG_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_BPM_LOAD;
        end
      end
      ST_BPM_LOAD: begin
        cmd_o.bpm_load = 1'b1;
        state_d        = ST_BPM_DIV;
      end
      ST_BPM_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_BPM_STORE;
        end
      end
      ST_BPM_STORE: begin
        cmd_o.bpm_store = 1'b1;
        state_d         = ST_RESULT;
      end
      ST_RESULT: begin
        // Wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

endmodule

// File: hw/rtl/ttbe_dp.sv
// ----------------------------------------------------------------------------
// ttbe_dp
// Datapath: tap ring, gap accumulator, shared restoring divider and the
// output register.
// ----------------------------------------------------------------------------
module ttbe_dp import ttbe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [TS_W-1:0]    timestamp_us_i,
  input  ttbe_cmd_t          cmd_i,
  output ttbe_sts_t          sts_o,
  output logic [COUNT_W-1:0] held_count_o,
  output logic               bpm_valid_o,
  output logic [AVG_W-1:0]   mean_gap_us_o,
  output logic [BPM_W-1:0]   bpm_x256_o
);

  // Ring bookkeeping
  logic [IDX_W-1:0]     wp_q, wp_d;
  logic [CNT_W-1:0]     held_q, held_d;
  logic [TIME_BITS-1:0] avg_q, avg_d;
  logic [BPM_W-1:0]     bpm_q, bpm_d;

  // Walk
  logic [IDX_W-1:0]     rd_addr_q, rd_addr_d;
  logic [CNT_W-1:0]     rd_left_q, rd_left_d;
  logic                 rd_pend_q, first_q, first_d;
  logic [TIME_BITS-1:0] prev_q, prev_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [GAP_W-1:0]     gaps_q, gaps_d;
  logic [TIME_BITS-1:0] rd_data;
  logic [IDX_W-1:0]     walk_start;

  // Divider
  logic [REM_W-1:0]     rem_q, rem_d, rem_shift;
  logic [SUM_W-1:0]     num_q, num_d;
  logic [SUM_W-1:0]     quo_q, quo_d;
  logic [TIME_BITS-1:0] den_q, den_d;
  logic [DIVCNT_W-1:0]  dcnt_q, dcnt_d;
  logic                 rem_ge;

  // Output register
  logic [COUNT_W-1:0]   out_count_q;
  logic [AVG_W-1:0]     out_avg_q;
  logic [BPM_W-1:0]     out_bpm_q;

  ttbe_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (TAP_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.tap_write),
    .waddr_i (wp_q),
    .wdata_i (timestamp_us_i[TIME_BITS-1:0]),
    .re_i    (cmd_i.walk_step),
    .raddr_i (rd_addr_q),
    .rdata_o (rd_data)
  );

  // Oldest held tap sits held entries behind the write pointer
  always_comb begin
    if (CNT_W'(wp_q) >= held_q) begin
      walk_start = IDX_W'(CNT_W'(wp_q) - held_q);
    end else begin
      walk_start = IDX_W'(CNT_W'(wp_q) + CNT_W'(TAP_WINDOW) - held_q);
    end
  end

  // Ring pointer, count and stored results
  always_comb begin
    wp_d   = wp_q;
    held_d = held_q;
    avg_d  = avg_q;
    bpm_d  = bpm_q;
    if (cmd_i.clear) begin
      wp_d   = '0;
      held_d = '0;
      avg_d  = '0;
      bpm_d  = '0;
    end else if (cmd_i.tap_write) begin
      wp_d = (wp_q == IDX_W'(TAP_WINDOW - 1)) ? '0 : wp_q + 1'b1;
      if (held_q != CNT_W'(TAP_WINDOW)) begin
        held_d = held_q + 1'b1;
      end
    end
    if (cmd_i.zero_result) begin
      avg_d = '0;
      bpm_d = '0;
    end
    if (cmd_i.bpm_load) begin
      avg_d = quo_q[TIME_BITS-1:0];
    end
    if (cmd_i.bpm_store) begin
      bpm_d = quo_q[BPM_W-1:0];
    end
  end

  // Walk the ring oldest to newest and accumulate positive gaps
  always_comb begin
    rd_addr_d = rd_addr_q;
    rd_left_d = rd_left_q;
    first_d   = first_q;
    prev_d    = prev_q;
    sum_d     = sum_q;
    gaps_d    = gaps_q;
    if (cmd_i.walk_init) begin
      rd_addr_d = walk_start;
      rd_left_d = held_q;
      first_d   = 1'b1;
      sum_d     = '0;
      gaps_d    = '0;
    end
    if (cmd_i.walk_step) begin
      rd_addr_d = (rd_addr_q == IDX_W'(TAP_WINDOW - 1)) ? '0 : rd_addr_q + 1'b1;
      rd_left_d = rd_left_q - 1'b1;
    end
    if (rd_pend_q) begin
      first_d = 1'b0;
      prev_d  = rd_data;
      if (!first_q && (rd_data > prev_q)) begin
        sum_d  = sum_q + SUM_W'(rd_data - prev_q);
        gaps_d = gaps_q + 1'b1;
      end
    end
  end

  // Restoring divider, one quotient bit per step
  assign rem_shift = {rem_q[REM_W-2:0], num_q[SUM_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, den_q});

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    den_d  = den_q;
    dcnt_d = dcnt_q;
    if (cmd_i.avg_load) begin
      rem_d  = '0;
      num_d  = sum_q;
      quo_d  = '0;
      den_d  = TIME_BITS'(gaps_q);
      dcnt_d = DIVCNT_W'(SUM_W);
    end else if (cmd_i.bpm_load) begin
      // Left-align the numerator so only its bits are shifted through
      rem_d  = '0;
      num_d  = {BPM_NUMERATOR, (SUM_W - BPM_W)'(0)};
      quo_d  = '0;
      den_d  = quo_q[TIME_BITS-1:0];
      dcnt_d = DIVCNT_W'(BPM_W);
    end else if (cmd_i.div_step) begin
      rem_d  = rem_ge ? rem_shift - {1'b0, den_q} : rem_shift;
      num_d  = {num_q[SUM_W-2:0], 1'b0};
      quo_d  = {quo_q[SUM_W-2:0], rem_ge};
      dcnt_d = dcnt_q - 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      held_q    <= '0;
      avg_q     <= '0;
      bpm_q     <= '0;
      rd_pend_q <= 1'b0;
      rd_left_q <= '0;
      dcnt_q    <= '0;
    end else begin
      wp_q      <= wp_d;
      held_q    <= held_d;
      avg_q     <= avg_d;
      bpm_q     <= bpm_d;
      rd_pend_q <= cmd_i.walk_step;
      rd_left_q <= rd_left_d;
      dcnt_q    <= dcnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    first_q   <= first_d;
    prev_q    <= prev_d;
    sum_q     <= sum_d;
    gaps_q    <= gaps_d;
    rem_q     <= rem_d;
    num_q     <= num_d;
    quo_q     <= quo_d;
    den_q     <= den_d;
    if (cmd_i.out_load) begin
      out_count_q <= COUNT_W'(held_q);
      out_avg_q   <= AVG_W'(avg_q);
      out_bpm_q   <= bpm_q;
    end
  end

  assign sts_o.multi     = (held_q >= CNT_W'(2));
  assign sts_o.walk_last = (rd_left_q == CNT_W'(1));
  assign sts_o.no_gaps   = (gaps_q == '0);
  assign sts_o.div_last  = (dcnt_q == DIVCNT_W'(1));

  assign held_count_o  = out_count_q;
  assign bpm_valid_o   = (out_avg_q != '0);
  assign mean_gap_us_o = out_avg_q;
  assign bpm_x256_o    = out_bpm_q;

endmodule

// File: hw/rtl/tap_tempo_bpm_estimator.sv
// ----------------------------------------------------------------------------
// tap_tempo_bpm_estimator
// Tap tempo estimator: mean positive tap interval and tempo times 256.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): a tap with a microsecond
// timestamp, or a clear. One request is taken at a time; in_stall_o is
// high from the transfer until the result has entered the output register.
// Output channel (out_valid_o / out_stall_i): one result per request, held
// in an output register, so the next request is taken while it waits.
// Sequence: a clear goes straight to the result, and a tap with fewer
// than two held taps goes from start to result. Otherwise the ring RAM
// is read one entry a cycle, oldest to newest, then one restoring divider
// gives one quotient bit a cycle, 54 steps for the average and 34 for the
// tempo; with no rising gap both divisions are skipped and zeros stored.
// Reset clears the tap count, write pointer and stored results; the ring
// needs no clearing since only written entries are ever read.
// When the receiver stalls, the result holds on the outputs; a finished
// later result waits in the sequencer until the register frees up.
// ----------------------------------------------------------------------------
module tap_tempo_bpm_estimator import ttbe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [TS_W-1:0]    timestamp_us_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COUNT_W-1:0] held_count_o,
  output logic               bpm_valid_o,
  output logic [AVG_W-1:0]   mean_gap_us_o,
  output logic [BPM_W-1:0]   bpm_x256_o
);

  ttbe_cmd_t cmd;
  ttbe_sts_t sts;

  ttbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ttbe_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .timestamp_us_i (timestamp_us_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .held_count_o   (held_count_o),
    .bpm_valid_o    (bpm_valid_o),
    .mean_gap_us_o  (mean_gap_us_o),
    .bpm_x256_o     (bpm_x256_o)
  );

endmodule

// File: tb/sv/tempo_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tempo_result_checker
// Watches both channels of the tap tempo estimator. Each request transfer
// runs through a tempo predictor kept here: a ring of tap times, a tap
// count, and the last mean gap and tempo. The predicted result is queued and
// each result transfer is compared against the oldest entry, field by field.
// ----------------------------------------------------------------------------
module tempo_result_checker import ttbe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               req_type_i,
  input  logic [TS_W-1:0]    timestamp_us_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [COUNT_W-1:0] held_count_i,
  input  logic               bpm_valid_i,
  input  logic [AVG_W-1:0]   mean_gap_us_i,
  input  logic [BPM_W-1:0]   bpm_x256_i,
  output int unsigned        error_count_o,
  output int unsigned        pending_o
);

  typedef struct packed {
    logic [COUNT_W-1:0] held_count;
    logic               bpm_valid;
    logic [AVG_W-1:0]   mean_gap;
    logic [BPM_W-1:0]   tempo;
  } tempo_result_t;

  // Predictor state
  logic [TS_W-1:0]  tap_times [TAP_WINDOW];
  logic [IDX_W-1:0] write_idx;
  int unsigned      taps_held;
  logic [AVG_W-1:0] mean_gap_us;
  logic [BPM_W-1:0] tempo_x256;

  tempo_result_t    expected_tempo_q [$];
  int unsigned      mismatches;

  // Apply one request to the predictor and return the result it causes
  task automatic advance_tempo_model(input logic kind, input logic [TS_W-1:0] stamp,
                                     output tempo_result_t res);
    logic [IDX_W-1:0] idx;
    logic [TS_W-1:0]  prev_ts;
    logic [TS_W-1:0]  cur_ts;
    logic [63:0]      gap_sum;
    logic [63:0]      gap_cnt;
    logic [63:0]      mean;
    if (kind == REQ_CLEAR) begin
      write_idx   = '0;
      taps_held   = 0;
      mean_gap_us = '0;
      tempo_x256  = '0;
    end else begin
      tap_times[write_idx] = stamp;
      write_idx = write_idx + 1'b1;
      if (taps_held < TAP_WINDOW) taps_held++;
      if (taps_held >= 2) begin
        // walk held taps oldest to newest, summing rising gaps only
        idx     = IDX_W'(write_idx - taps_held);
        prev_ts = tap_times[idx];
        gap_sum = '0;
        gap_cnt = '0;
        for (int k = 1; k < taps_held; k++) begin
          idx    = idx + 1'b1;
          cur_ts = tap_times[idx];
          if (cur_ts > prev_ts) begin
            gap_sum += 64'(cur_ts - prev_ts);
            gap_cnt++;
          end
          prev_ts = cur_ts;
        end
        mean        = (gap_cnt != 0) ? gap_sum / gap_cnt : 64'd0;
        mean_gap_us = AVG_W'(mean);
        tempo_x256  = (mean != 0) ? BPM_W'(64'(BPM_NUMERATOR) / mean) : '0;
      end
    end
    res.held_count = COUNT_W'(taps_held);
    res.bpm_valid  = (mean_gap_us != '0);
    res.mean_gap   = mean_gap_us;
    res.tempo      = tempo_x256;
  endtask

  // Compare result transfers, then predict for request transfers
  always @(posedge clk_i or negedge rst_ni) begin
    tempo_result_t want;
    if (!rst_ni) begin
      write_idx   = '0;
      taps_held   = 0;
      mean_gap_us = '0;
      tempo_x256  = '0;
      mismatches  = 0;
      expected_tempo_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_tempo_q.size() == 0) begin
          $error("result transfer with no request outstanding: held_count %0d bpm_x256 %0d",
                 held_count_i, bpm_x256_i);
          mismatches++;
        end else begin
          want = expected_tempo_q.pop_front();
          if (held_count_i !== want.held_count) begin
            $error("held_count: expected %0d, actual %0d", want.held_count, held_count_i);
            mismatches++;
          end
          if (bpm_valid_i !== want.bpm_valid) begin
            $error("bpm_valid: expected %0d, actual %0d", want.bpm_valid, bpm_valid_i);
            mismatches++;
          end
          if (mean_gap_us_i !== want.mean_gap) begin
            $error("mean_gap_us: expected %0d, actual %0d",
                   want.mean_gap, mean_gap_us_i);
            mismatches++;
          end
          if (bpm_x256_i !== want.tempo) begin
            $error("bpm_x256: expected %0d, actual %0d", want.tempo, bpm_x256_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        advance_tempo_model(req_type_i, timestamp_us_i, want);
        expected_tempo_q.push_back(want);
      end
    end
    error_count_o <= mismatches;
    pending_o     <= expected_tempo_q.size();
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives taps and clears into the tap tempo estimator: a directed opening
// over the edge cases, then runs of tap times with human, tiny, duplicate,
// backward and huge intervals mixed with stray taps and clears. Both sides
// idle at random; the receiver also holds off once for a long stretch.
// The checker beside the block reports mismatches; a watchdog ends a hang.
// ----------------------------------------------------------------------------
module testbench import ttbe_pkg::*; ();

  localparam int unsigned    RANDOM_ITEMS = 450;
  localparam int unsigned    HOLD_CYCLES  = 400;
  localparam int unsigned    DRAIN_CYCLES = 200;
  localparam int unsigned    STALL_LIMIT  = 5000;
  localparam logic [TS_W-1:0] TS_MAX      = '1;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               req_type_i;
  logic [TS_W-1:0]    timestamp_us_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [COUNT_W-1:0] held_count_o;
  logic               bpm_valid_o;
  logic [AVG_W-1:0]   mean_gap_us_o;
  logic [BPM_W-1:0]   bpm_x256_o;

  int unsigned        error_count;
  int unsigned        pending_count;
  int unsigned        idle_cycles;
  bit                 quiet;
  bit                 hold_go;
  bit                 hold_done;
  logic [TS_W-1:0]    now_us;

  tap_tempo_bpm_estimator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .timestamp_us_i (timestamp_us_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .held_count_o   (held_count_o),
    .bpm_valid_o    (bpm_valid_o),
    .mean_gap_us_o  (mean_gap_us_o),
    .bpm_x256_o     (bpm_x256_o)
  );

  tempo_result_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .req_type_i     (req_type_i),
    .timestamp_us_i (timestamp_us_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .held_count_i   (held_count_o),
    .bpm_valid_i    (bpm_valid_o),
    .mean_gap_us_i  (mean_gap_us_o),
    .bpm_x256_i     (bpm_x256_o),
    .error_count_o  (error_count),
    .pending_o      (pending_count)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [TS_W-1:0] random_stamp();
    return TS_W'({$urandom, $urandom});
  endfunction

  // Offer one request, idling first now and then; hold it until the transfer
  task automatic send_request(input logic kind, input logic [TS_W-1:0] stamp);
    if (!quiet && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= kind;
    timestamp_us_i <= stamp;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  // Edge cases: empty clear, single tap, equal and falling times,
  // unit gap (fastest tempo), huge gap (zero tempo with a valid mean)
  task automatic directed_phase();
    send_request(REQ_CLEAR, TS_MAX);
    send_request(REQ_TAP, '0);
    send_request(REQ_TAP, '0);
    send_request(REQ_TAP, 48'd1);
    send_request(REQ_TAP, TS_MAX);
    send_request(REQ_TAP, 48'd5);
    send_request(REQ_CLEAR, '0);
    send_request(REQ_TAP, TS_MAX);
    send_request(REQ_TAP, '0);
    send_request(REQ_TAP, 48'd500000);
    send_request(REQ_TAP, 48'd1000000);
    send_request(REQ_TAP, 48'd1000001);
    send_request(REQ_CLEAR, random_stamp());
    send_request(REQ_TAP, 48'd100);
    send_request(REQ_TAP, 48'd20000000100);
    send_request(REQ_TAP, 48'd15360000100 + 48'd20000000000);
    send_request(REQ_CLEAR, '0);
  endtask

  // Mostly rising tap runs with random spacing, some noise and clears
  task automatic random_phase();
    int unsigned pick;
    now_us = random_stamp();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 120) hold_go = 1'b1;
      quiet = (n >= 200 && n < 280);
      if (n == 320) wait_for_results();
      pick = $urandom_range(999);
      if (pick < 12) begin
        send_request(REQ_CLEAR, random_stamp());
        now_us = random_stamp();
      end else if (pick < 50) begin
        send_request(REQ_TAP, random_stamp());
      end else begin
        pick = $urandom_range(99);
        if (pick < 70) now_us += $urandom_range(1500000, 250000);
        else if (pick < 80) now_us += $urandom_range(100, 1);
        else if (pick < 86) now_us -= $urandom_range(50000, 1);
        else if (pick < 94) now_us += random_stamp() >> $urandom_range(40, 0);
        send_request(REQ_TAP, now_us);
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    req_type_i     <= REQ_TAP;
    timestamp_us_i <= '0;
    quiet     = 1'b0;
    hold_go   = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    directed_phase();
    random_phase();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off, a quiet stretch
  initial begin
    out_stall_i <= 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= (!quiet && $urandom_range(99) < 7);
      end
    end
  end

  // Watchdog: end the run after too long without any transfer
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/ttbe_pkg.sv
hw/rtl/ttbe_ram.sv
hw/rtl/ttbe_ctrl.sv
hw/rtl/ttbe_dp.sv
hw/rtl/tap_tempo_bpm_estimator.sv
tb/sv/tempo_result_checker.sv
tb/sv/testbench.sv
